// ===== design/tdb_pkg.sv =====
// Shared types, register indexes and reset values of the tick debounce blink timer.
package tdb_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int LED_COUNT = 3;
   localparam int CFG_WIDTH = 16;
   localparam int SOUND_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERVAL_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOUND_LENGTH        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_PERIOD_NORMAL = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_PERIOD_FAST   = 3'd4;

   localparam logic [CFG_WIDTH-1:0]   INTERVAL_LENGTH_RESET     = 16'd10;
   localparam logic [CFG_WIDTH-1:0]   DEBOUNCE_LENGTH_RESET     = 16'd20;
   localparam logic [SOUND_WIDTH-1:0] SOUND_LENGTH_RESET        = 8'd100;
   localparam logic [CFG_WIDTH-1:0]   BLINK_PERIOD_NORMAL_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0]   BLINK_PERIOD_FAST_RESET   = 16'd10;

   typedef enum logic [1:0] {
      LED_STEADY       = 2'd0,
      LED_BLINK_NORMAL = 2'd1,
      LED_BLINK_FAST   = 2'd2
   } led_mode_type;

   typedef struct packed {
      logic event_hit;
      logic confirmed;
   } deb_status_type;

endpackage

// ===== design/tick_debounce_blink_timer.sv =====
// Top level: interval divider, sound timer, debounce and LED lanes, result register.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle; the single result register is refilled in the
// cycle it is taken, so input ready holds while the result side keeps up.
// Reset clears all counters, latches and phases, loads the register reset values
// and empties the result register; no clearing pass is needed.
module tick_debounce_blink_timer #(
   parameter int COUNT_WIDTH = tdb_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_direction_pin,
   input  logic                                req_limit_pin,
   input  logic                                req_sound_trigger,
   input  logic [1:0]                          req_acc_led_mode,
   input  logic [1:0]                          req_brake_led_mode,
   input  logic [1:0]                          req_dir_led_mode,
   input  logic                                req_acc_led_steady,
   input  logic                                req_brake_led_steady,
   input  logic                                req_dir_led_steady,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_interval_pulse,
   output logic                                rsp_direction_event,
   output logic                                rsp_direction_confirmed,
   output logic                                rsp_limit_event,
   output logic                                rsp_limit_confirmed,
   output logic                                rsp_buzzer_on,
   output logic                                rsp_acc_led,
   output logic                                rsp_brake_led,
   output logic                                rsp_dir_led,
   input  logic                                csr_we,
   input  logic [tdb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tdb_pkg::CFG_WIDTH-1:0]       csr_wdata
);

   localparam int CMP_W = (COUNT_WIDTH > tdb_pkg::CFG_WIDTH) ? COUNT_WIDTH : tdb_pkg::CFG_WIDTH;

   logic [tdb_pkg::CFG_WIDTH-1:0]   interval_length_ff;
   logic [tdb_pkg::CFG_WIDTH-1:0]   debounce_length_ff;
   logic [tdb_pkg::SOUND_WIDTH-1:0] sound_length_ff;
   logic [tdb_pkg::CFG_WIDTH-1:0]   period_normal_ff;
   logic [tdb_pkg::CFG_WIDTH-1:0]   period_fast_ff;

   logic [COUNT_WIDTH-1:0]          div_counter_ff, div_counter_in, interval_inc;
   logic                            pulse;
   logic                            sound_active_ff, sound_active_in, sound_req;
   logic [tdb_pkg::SOUND_WIDTH-1:0] tone_counter_ff, tone_counter_in, sound_inc;

   tdb_pkg::deb_status_type         dir_status, lim_status;
   logic [tdb_pkg::LED_COUNT-1:0]   led_level;
   logic [tdb_pkg::LED_COUNT-1:0]   lane_steady;
   logic [1:0]                      lane_mode [tdb_pkg::LED_COUNT];

   logic                            rsp_valid_ff;
   logic [8:0]                      result_ff, result_in;
   logic                            step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_length_ff <= tdb_pkg::INTERVAL_LENGTH_RESET;
         debounce_length_ff <= tdb_pkg::DEBOUNCE_LENGTH_RESET;
         sound_length_ff <= tdb_pkg::SOUND_LENGTH_RESET;
         period_normal_ff <= tdb_pkg::BLINK_PERIOD_NORMAL_RESET;
         period_fast_ff <= tdb_pkg::BLINK_PERIOD_FAST_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tdb_pkg::CSR_INTERVAL_LENGTH: interval_length_ff <= csr_wdata;
            tdb_pkg::CSR_DEBOUNCE_LENGTH: debounce_length_ff <= csr_wdata;
            tdb_pkg::CSR_SOUND_LENGTH: sound_length_ff <= csr_wdata[tdb_pkg::SOUND_WIDTH-1:0];
            tdb_pkg::CSR_BLINK_PERIOD_NORMAL: period_normal_ff <= csr_wdata;
            tdb_pkg::CSR_BLINK_PERIOD_FAST: period_fast_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      interval_inc = div_counter_ff + COUNT_WIDTH'(1);
      pulse = (CMP_W'(interval_inc) == CMP_W'(interval_length_ff));
      div_counter_in = pulse ? '0 : interval_inc;

      sound_req = sound_active_ff || req_sound_trigger;
      sound_inc = tone_counter_ff + 8'd1;
      sound_active_in = sound_req;
      tone_counter_in = tone_counter_ff;
      if (sound_req) begin
         tone_counter_in = sound_inc;
         if (sound_inc > sound_length_ff) begin
            tone_counter_in = '0;
            sound_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_counter_ff <= '0;
         sound_active_ff <= 1'b0;
         tone_counter_ff <= '0;
      end else if (step) begin
         div_counter_ff <= div_counter_in;
         sound_active_ff <= sound_active_in;
         tone_counter_ff <= tone_counter_in;
      end
   end

   tdb_debounce_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_dir_lane (
      .clock(clock), .reset(reset), .step(step), .pressed(req_direction_pin),
      .debounce_length(debounce_length_ff), .status(dir_status)
   );

   tdb_debounce_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lim_lane (
      .clock(clock), .reset(reset), .step(step), .pressed(req_limit_pin),
      .debounce_length(debounce_length_ff), .status(lim_status)
   );

   assign lane_mode[0] = req_acc_led_mode;
   assign lane_mode[1] = req_brake_led_mode;
   assign lane_mode[2] = req_dir_led_mode;
   assign lane_steady = {req_dir_led_steady, req_brake_led_steady, req_acc_led_steady};

   for (genvar i = 0; i < tdb_pkg::LED_COUNT; i++) begin : g_led
      tdb_blink_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_led_lane (
         .clock(clock), .reset(reset), .step(step), .mode(lane_mode[i]),
         .steady(lane_steady[i]), .period_normal(period_normal_ff),
         .period_fast(period_fast_ff), .led(led_level[i])
      );
   end

   assign result_in = {led_level[2], led_level[1], led_level[0], sound_active_in,
                       lim_status.confirmed, lim_status.event_hit,
                       dir_status.confirmed, dir_status.event_hit, pulse};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_interval_pulse = result_ff[0];
   assign rsp_direction_event = result_ff[1];
   assign rsp_direction_confirmed = result_ff[2];
   assign rsp_limit_event = result_ff[3];
   assign rsp_limit_confirmed = result_ff[4];
   assign rsp_buzzer_on = result_ff[5];
   assign rsp_acc_led = result_ff[6];
   assign rsp_brake_led = result_ff[7];
   assign rsp_dir_led = result_ff[8];

`ifndef NO_ASSERTIONS
   a_event_confirms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_direction_event || rsp_limit_event) |->
         ((!rsp_direction_event || rsp_direction_confirmed) &&
          (!rsp_limit_event || rsp_limit_confirmed)))
      else $error("debounce event without confirmed level");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("accepted item produced no result");

   a_pulse_clears_counter: assert property (@(posedge clock) disable iff (reset)
      step && pulse |=> div_counter_ff == '0)
      else $error("interval counter not cleared on pulse");
`endif

endmodule

// ===== design/tdb_debounce_lane.sv =====
// One switch debounce lane: run counter and press latch.
module tdb_debounce_lane #(
   parameter int COUNT_WIDTH = tdb_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         pressed,
   input  logic [tdb_pkg::CFG_WIDTH-1:0] debounce_length,
   output tdb_pkg::deb_status_type      status
);

   localparam int CMP_W = (COUNT_WIDTH > tdb_pkg::CFG_WIDTH) ? COUNT_WIDTH : tdb_pkg::CFG_WIDTH;

   logic [COUNT_WIDTH-1:0] run_ff, run_in, run_inc;
   logic                   latched_ff, latched_in;
   logic                   hit;

   always_comb begin
      run_inc = run_ff + COUNT_WIDTH'(1);
      run_in = run_ff;
      latched_in = latched_ff;
      hit = 1'b0;
      if (!pressed) begin
         run_in = '0;
         latched_in = 1'b0;
      end else if (!latched_ff) begin
         run_in = run_inc;
         if (CMP_W'(run_inc) == CMP_W'(debounce_length)) begin
            run_in = '0;
            latched_in = 1'b1;
            hit = 1'b1;
         end
      end
   end

   assign status.event_hit = hit;
   assign status.confirmed = latched_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         latched_ff <= 1'b0;
      end else if (step) begin
         run_ff <= run_in;
         latched_ff <= latched_in;
      end
   end

endmodule

// ===== design/tdb_blink_lane.sv =====
// One LED lane: blink counter and phase, or the steady level.
module tdb_blink_lane #(
   parameter int COUNT_WIDTH = tdb_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [1:0]                    mode,
   input  logic                          steady,
   input  logic [tdb_pkg::CFG_WIDTH-1:0] period_normal,
   input  logic [tdb_pkg::CFG_WIDTH-1:0] period_fast,
   output logic                          led
);

   localparam int CMP_W = (COUNT_WIDTH > tdb_pkg::CFG_WIDTH) ? COUNT_WIDTH : tdb_pkg::CFG_WIDTH;

   logic [COUNT_WIDTH-1:0]        count_ff, count_in, count_inc;
   logic                          phase_ff, phase_in;
   logic [tdb_pkg::CFG_WIDTH-1:0] period;
   logic                          blinking;

   always_comb begin
      count_inc = count_ff + COUNT_WIDTH'(1);
      period = period_normal;
      blinking = 1'b0;
      case (tdb_pkg::led_mode_type'(mode))
         tdb_pkg::LED_BLINK_NORMAL: begin
            blinking = 1'b1;
         end
         tdb_pkg::LED_BLINK_FAST: begin
            blinking = 1'b1;
            period = period_fast;
         end
         default: begin
            blinking = 1'b0;
         end
      endcase
      if (blinking) begin
         count_in = count_inc;
         phase_in = phase_ff;
         if (CMP_W'(count_inc) > CMP_W'(period)) begin
            count_in = '0;
            phase_in = !phase_ff;
         end
      end else begin
         count_in = '0;
         phase_in = steady;
      end
   end

   assign led = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

endmodule
